### rtl/x25_channel_output_fsm_defines.svh
// assertion macros shared by the x25 channel output rtl
// no dependencies; included by files that carry assertions
`ifndef X25_CHANNEL_OUTPUT_FSM_DEFINES_SVH
`define X25_CHANNEL_OUTPUT_FSM_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define X25CO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("x25co: implication check failed");

// next-cycle implication, checked while out of reset
`define X25CO_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("x25co: next-cycle check failed");

`endif

### rtl/x25co_pkg.sv
// shared types and codes for the x25 channel output block
// no dependencies
package x25co_pkg;

	localparam int SEQ_MODULUS_DEF = 8;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

	// packet type codes on the request side
	localparam logic [3:0] OP_CALL         = 4'd0;
	localparam logic [3:0] OP_ACCEPTED     = 4'd1;
	localparam logic [3:0] OP_CLEAR        = 4'd2;
	localparam logic [3:0] OP_CLEAR_CONF   = 4'd3;
	localparam logic [3:0] OP_DATA         = 4'd4;
	localparam logic [3:0] OP_INTR         = 4'd5;
	localparam logic [3:0] OP_INTR_CONF    = 4'd6;
	localparam logic [3:0] OP_RR           = 4'd7;
	localparam logic [3:0] OP_RNR          = 4'd8;
	localparam logic [3:0] OP_RESET        = 4'd9;
	localparam logic [3:0] OP_RESET_CONF   = 4'd10;
	localparam logic [3:0] OP_RESTART      = 4'd11;
	localparam logic [3:0] OP_RESTART_CONF = 4'd12;

	// result action codes
	localparam logic [1:0] ACT_SENT = 2'd0;
	localparam logic [1:0] ACT_HELD = 2'd1;
	localparam logic [1:0] ACT_DROP = 2'd2;

	// register indexes on the apb port
	localparam logic [1:0] REG_WINDOW_SIZE     = 2'd0;
	localparam logic [1:0] REG_RESTART_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_CALL_TIMEOUT    = 2'd2;
	localparam logic [1:0] REG_CLEAR_TIMEOUT   = 2'd3;

	typedef enum logic [3:0] {
		CLS_CALL,
		CLS_ACCEPT,
		CLS_CLEAR,
		CLS_CLEAR_CONF,
		CLS_DATA,
		CLS_INTR,
		CLS_INTR_CONF,
		CLS_FLOW,
		CLS_RESET,
		CLS_RESET_CONF,
		CLS_RESTART,
		CLS_RESTART_CONF,
		CLS_INVALID
	} pkt_cls_t;

	typedef struct packed {
		pkt_cls_t   cls;
		logic       from_template;
		logic [2:0] recv_seq;
		logic [2:0] peer_ack_edge;
		logic       peer_busy;
		logic       window_reopen;
	} item_t;

	typedef struct packed {
		logic [2:0]  window_size;
		logic [15:0] restart_timeout;
		logic [15:0] call_timeout;
		logic [15:0] clear_timeout;
	} cfg_t;

endpackage

### rtl/x25co_queue.sv
// two-entry queue between the decode front and the channel back end
// depends on x25co_pkg
module x25co_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  x25co_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output x25co_pkg::item_t head_item
);
	import x25co_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/x25co_front.sv
// request-side decode: unpacks the stream and classifies the packet type
// depends on x25co_pkg; feeds x25co_queue
module x25co_front (
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,   // from_template, recv_seq[2:0], peer_ack_edge[2:0],
	                                    // peer_busy, window_reopen, zero fill
	input  logic [3:0]       s_tuser,   // opcode
	input  logic             queue_full,
	output logic             push,
	output x25co_pkg::item_t push_item
);
	import x25co_pkg::*;

	function automatic pkt_cls_t classify(input logic [3:0] op);
		pkt_cls_t c;
		case (op)
			OP_CALL:         c = CLS_CALL;
			OP_ACCEPTED:     c = CLS_ACCEPT;
			OP_CLEAR:        c = CLS_CLEAR;
			OP_CLEAR_CONF:   c = CLS_CLEAR_CONF;
			OP_DATA:         c = CLS_DATA;
			OP_INTR:         c = CLS_INTR;
			OP_INTR_CONF:    c = CLS_INTR_CONF;
			OP_RR:           c = CLS_FLOW;
			OP_RNR:          c = CLS_FLOW;
			OP_RESET:        c = CLS_RESET;
			OP_RESET_CONF:   c = CLS_RESET_CONF;
			OP_RESTART:      c = CLS_RESTART;
			OP_RESTART_CONF: c = CLS_RESTART_CONF;
			default:         c = CLS_INVALID;
		endcase
		return c;
	endfunction

	assign s_tready = !queue_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		push_item.cls           = classify(s_tuser);
		push_item.from_template = s_tdata[0];
		push_item.recv_seq      = s_tdata[3:1];
		push_item.peer_ack_edge = s_tdata[6:4];
		push_item.peer_busy     = s_tdata[7];
		push_item.window_reopen = s_tdata[8];
	end

endmodule

### rtl/x25co_back.sv
// channel back end: flow control hold, state moves, sequence stamping, result register
// depends on x25co_pkg and x25_channel_output_fsm_defines.svh
`include "x25_channel_output_fsm_defines.svh"

module x25co_back #(
	parameter int SEQ_MODULUS = x25co_pkg::SEQ_MODULUS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  x25co_pkg::cfg_t  cfg,
	input  logic             head_valid,
	input  x25co_pkg::item_t head_item,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata,   // send_seq_out[2:0], recv_seq_out[2:0], timer_start,
	                                    // timer_value[15:0], chan_state[2:0], retry_count[7:0],
	                                    // window_closed, reset_pending, intr_conf_pending, zero fill
	output logic [1:0]       m_tuser    // action
);
	import x25co_pkg::*;

	localparam int SEQ_W = $clog2(SEQ_MODULUS);
	localparam int SUM_W = SEQ_W + 1;
	localparam logic [SUM_W-1:0] MOD = SUM_W'(SEQ_MODULUS);

	typedef enum logic [2:0] {
		ST_READY      = 3'd0,
		ST_RECV_CALL  = 3'd1,
		ST_SENT_CALL  = 3'd2,
		ST_DATA       = 3'd3,
		ST_RECV_CLEAR = 3'd4,
		ST_SENT_CLEAR = 3'd5
	} chan_st_t;

	chan_st_t          st_q, st_n;
	logic [SEQ_W-1:0]  send_seq_q, send_seq_n;
	logic [7:0]        retries_q, retries_n;
	logic              wfull_q, wfull_n;
	logic              rflag_q, rflag_n;
	logic              iflag_q, iflag_n;

	logic              out_valid_q;
	logic [36:0]       res_q;
	logic [1:0]        act_q;

	logic              wfull_eff, hold, ok;
	logic [1:0]        act;
	logic [2:0]        ps, pr;
	logic              tstart;
	logic [15:0]       tval;
	logic [SEQ_W-1:0]  send_inc;
	logic [SUM_W-1:0]  pr_sum, pr_mod, edge_sum, win_edge;
	logic [7:0]        retries_bump;

	assign pop = head_valid && (!out_valid_q || m_tready);

	always_comb begin
		send_inc = (send_seq_q == SEQ_W'(SEQ_MODULUS - 1)) ? '0 : send_seq_q + 1'b1;
		pr_sum   = SUM_W'(head_item.recv_seq) + 1'b1;
		pr_mod   = (pr_sum >= MOD) ? pr_sum - MOD : pr_sum;
		edge_sum = SUM_W'(head_item.peer_ack_edge) + SUM_W'(cfg.window_size);
		win_edge = (edge_sum >= MOD) ? edge_sum - MOD : edge_sum;
		retries_bump = (retries_q == 8'hff) ? retries_q : retries_q + 1'b1;
	end

	always_comb begin
		wfull_eff  = wfull_q && !head_item.window_reopen;
		hold       = !head_item.from_template &&
		             (head_item.peer_busy || wfull_eff || rflag_q);
		st_n       = st_q;
		send_seq_n = send_seq_q;
		retries_n  = retries_q;
		wfull_n    = wfull_eff;
		rflag_n    = rflag_q;
		iflag_n    = iflag_q;
		ps         = '0;
		pr         = '0;
		tstart     = 1'b0;
		tval       = '0;
		ok         = 1'b1;
		act        = ACT_SENT;
		if (hold) begin
			act = ACT_HELD;
		end else begin
			case (head_item.cls)
				CLS_CALL: begin
					if (st_q == ST_READY) begin
						st_n   = ST_SENT_CALL;
						tstart = 1'b1;
						tval   = cfg.call_timeout;
					end else ok = 1'b0;
				end
				CLS_ACCEPT: begin
					if (st_q == ST_RECV_CALL) st_n = ST_DATA;
					else ok = 1'b0;
				end
				CLS_CLEAR: begin
					if (st_q == ST_RECV_CALL || st_q == ST_SENT_CALL || st_q == ST_DATA) begin
						// first clear restarts the retry count at one
						st_n      = ST_SENT_CLEAR;
						retries_n = 8'd1;
						tstart    = 1'b1;
						tval      = cfg.clear_timeout;
					end else if (st_q == ST_SENT_CLEAR) begin
						retries_n = retries_bump;
						tstart    = 1'b1;
						tval      = cfg.clear_timeout;
					end else ok = 1'b0;
				end
				CLS_CLEAR_CONF: begin
					if (st_q == ST_RECV_CLEAR || st_q == ST_SENT_CLEAR || st_q == ST_READY)
						st_n = ST_READY;
					else ok = 1'b0;
				end
				CLS_DATA: begin
					if (st_q == ST_DATA) begin
						ps         = send_seq_q[2:0];
						pr         = pr_mod[2:0];
						send_seq_n = send_inc;
						if (SUM_W'(send_inc) == win_edge) wfull_n = 1'b1;
					end else ok = 1'b0;
				end
				CLS_INTR: begin
					if (st_q == ST_DATA) iflag_n = 1'b1;
					else ok = 1'b0;
				end
				CLS_INTR_CONF: begin
					if (st_q != ST_DATA) ok = 1'b0;
				end
				CLS_FLOW: begin
					if (st_q == ST_DATA) pr = pr_mod[2:0];
					else ok = 1'b0;
				end
				CLS_RESET: begin
					if (st_q == ST_DATA) rflag_n = 1'b1;
					else ok = 1'b0;
				end
				CLS_RESET_CONF: begin
					if (st_q == ST_DATA) rflag_n = 1'b0;
					else ok = 1'b0;
				end
				CLS_RESTART: begin
					if (st_q == ST_READY) begin
						tstart = 1'b1;
						tval   = cfg.restart_timeout;
					end else ok = 1'b0;
				end
				CLS_RESTART_CONF: begin
					if (st_q != ST_READY) ok = 1'b0;
				end
				default: ok = 1'b0;
			endcase
			if (!ok) begin
				act = ACT_DROP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_READY;
			send_seq_q  <= '0;
			retries_q   <= '0;
			wfull_q     <= 1'b0;
			rflag_q     <= 1'b0;
			iflag_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				st_q        <= st_n;
				send_seq_q  <= send_seq_n;
				retries_q   <= retries_n;
				wfull_q     <= wfull_n;
				rflag_q     <= rflag_n;
				iflag_q     <= iflag_n;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			act_q <= act;
			res_q <= {iflag_n, rflag_n, wfull_n, retries_n, 3'(st_n), tval, tstart, pr, ps};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, res_q};
	assign m_tuser  = act_q;

	`X25CO_ASSERT_IMP(a_no_stamp_unless_sent, clk, arst_n,
		m_tvalid && m_tuser != ACT_SENT, m_tdata[6:0] == 7'd0)
	`X25CO_ASSERT_NXT(a_state_moves_on_pop, clk, arst_n,
		!pop, $stable(st_q) && $stable(send_seq_q) && $stable(retries_q))
	`X25CO_ASSERT_IMP(a_wfull_rises_on_pop, clk, arst_n,
		$rose(wfull_q), $past(pop))
	`X25CO_ASSERT_IMP(a_pop_needs_head, clk, arst_n,
		pop, head_valid)

endmodule

### rtl/x25_channel_output_fsm.sv
// Output side of one X.25 logical channel. Each request on the s_ stream is one
// outgoing packet descriptor; each gives exactly one result on the m_ stream
// saying whether it was sent, held by flow control or dropped, with the stamped
// P(S)/P(R), timer load and channel status after the packet. One request is
// taken per clock cycle while the queue is not full: the decode front pushes into
// a two-entry queue and the back end decides one packet per cycle while the result
// register can take it, so each request passes a queue entry and then the result
// register before m_tvalid. s_tready falls only when the queue holds two requests,
// which happens while the result register is stalled. Sequence numbers run modulo
// SEQ_MODULUS. Configuration goes through the apb port while no packet is in
// flight (a rule for the user, not enforced by the block); registers at 0x0
// window_size, 0x4 restart_timeout, 0x8 call_timeout, 0xc clear_timeout.
// depends on x25co_pkg, x25co_front, x25co_queue, x25co_back
module x25_channel_output_fsm #(
	parameter int SEQ_MODULUS = x25co_pkg::SEQ_MODULUS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // from_template, recv_seq[2:0], peer_ack_edge[2:0],
	                               // peer_busy, window_reopen, zero fill
	input  logic [3:0]  s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // send_seq_out[2:0], recv_seq_out[2:0], timer_start,
	                               // timer_value[15:0], chan_state[2:0], retry_count[7:0],
	                               // window_closed, reset_pending, intr_conf_pending, zero fill
	output logic [1:0]  m_tuser,   // action
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import x25co_pkg::*;

	cfg_t  cfg_q;
	logic  cfg_wr;
	logic  queue_full, push, pop, head_valid;
	item_t push_item, head_item;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size     <= 3'd2;
			cfg_q.restart_timeout <= 16'd180;
			cfg_q.call_timeout    <= 16'd200;
			cfg_q.clear_timeout   <= 16'd180;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_WINDOW_SIZE:     cfg_q.window_size     <= pwdata[2:0];
				REG_RESTART_TIMEOUT: cfg_q.restart_timeout <= pwdata[15:0];
				REG_CALL_TIMEOUT:    cfg_q.call_timeout    <= pwdata[15:0];
				REG_CLEAR_TIMEOUT:   cfg_q.clear_timeout   <= pwdata[15:0];
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WINDOW_SIZE:     prdata = {29'd0, cfg_q.window_size};
			REG_RESTART_TIMEOUT: prdata = {16'd0, cfg_q.restart_timeout};
			REG_CALL_TIMEOUT:    prdata = {16'd0, cfg_q.call_timeout};
			REG_CLEAR_TIMEOUT:   prdata = {16'd0, cfg_q.clear_timeout};
			default:             prdata = '0;
		endcase
	end

	x25co_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	x25co_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	x25co_back #(
		.SEQ_MODULUS (SEQ_MODULUS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

### sim/x25_channel_output_fsm_tb.sv
// self-checking bench for the x25 channel output block: drives packet requests
// and apb writes, predicts every result in a scoreboard class and checks them
// depends on x25co_pkg and x25_channel_output_fsm
`timescale 1ns / 100ps

module x25_channel_output_fsm_tb;
	import x25co_pkg::*;

	typedef enum logic [2:0] {
		CH_READY,
		CH_RECV_CALL,
		CH_SENT_CALL,
		CH_DATA,
		CH_RECV_CLEAR,
		CH_SENT_CLEAR
	} chan_state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  ps;
		logic [2:0]  pr;
		logic        tstart;
		logic [15:0] tval;
		logic [2:0]  chan;
		logic [7:0]  retries;
		logic        wclosed;
		logic        rpend;
		logic        ipend;
	} pkt_result_t;

	class channel_book;
		logic [2:0]  win_size = 3'd2;
		logic [15:0] restart_to = 16'd180;
		logic [15:0] call_to = 16'd200;
		logic [15:0] clear_to = 16'd180;
		chan_state_t chan = CH_READY;
		logic [2:0]  next_ps = '0;
		logic [2:0]  in_win = '0;
		logic [2:0]  last_pr = '0;
		logic [7:0]  retries = '0;
		logic [7:0]  peak_retries = '0;
		bit          win_full, rst_pend, intr_pend;
		pkt_result_t due[$];
		int          errors, n_sent, n_held, n_drop;

		function logic [2:0] stamp_pr(logic [2:0] rseq);
			in_win = rseq + 3'd1;
			last_pr = in_win;
			return in_win;
		endfunction

		function void note_request(logic [3:0] op, bit tmpl, logic [2:0] rseq,
				logic [2:0] ack, bit busy, bit reopen);
			pkt_result_t r;
			bit valid_here;
			r = '0;
			valid_here = 1'b1;
			// reopen takes effect even on a held or dropped packet
			if (reopen)
				win_full = 1'b0;
			if (!tmpl && (busy || win_full || rst_pend)) begin
				r.action = ACT_HELD;
			end else begin
				case (op)
				OP_CALL: begin
					if (chan == CH_READY) begin
						chan = CH_SENT_CALL;
						r.tstart = 1'b1;
						r.tval = call_to;
					end else valid_here = 1'b0;
				end
				OP_ACCEPTED: begin
					if (chan == CH_RECV_CALL) chan = CH_DATA;
					else valid_here = 1'b0;
				end
				OP_CLEAR: begin
					if (chan == CH_RECV_CALL || chan == CH_SENT_CALL || chan == CH_DATA) begin
						chan = CH_SENT_CLEAR;
						retries = '0;
					end
					// first clear or a retransmission from sent clear
					if (chan == CH_SENT_CLEAR) begin
						r.tstart = 1'b1;
						r.tval = clear_to;
						if (retries != 8'hff)
							retries = retries + 8'd1;
					end else valid_here = 1'b0;
				end
				OP_CLEAR_CONF: begin
					if (chan == CH_RECV_CLEAR || chan == CH_SENT_CLEAR || chan == CH_READY)
						chan = CH_READY;
					else valid_here = 1'b0;
				end
				OP_DATA: begin
					if (chan == CH_DATA) begin
						r.ps = next_ps;
						r.pr = stamp_pr(rseq);
						next_ps = next_ps + 3'd1;
						if (next_ps == 3'(ack + win_size))
							win_full = 1'b1;
					end else valid_here = 1'b0;
				end
				OP_INTR: begin
					if (chan == CH_DATA) intr_pend = 1'b1;
					else valid_here = 1'b0;
				end
				OP_INTR_CONF: begin
					if (chan != CH_DATA) valid_here = 1'b0;
				end
				OP_RR, OP_RNR: begin
					if (chan == CH_DATA) r.pr = stamp_pr(rseq);
					else valid_here = 1'b0;
				end
				OP_RESET: begin
					if (chan == CH_DATA) rst_pend = 1'b1;
					else valid_here = 1'b0;
				end
				OP_RESET_CONF: begin
					if (chan == CH_DATA) rst_pend = 1'b0;
					else valid_here = 1'b0;
				end
				OP_RESTART: begin
					if (chan == CH_READY) begin
						r.tstart = 1'b1;
						r.tval = restart_to;
					end else valid_here = 1'b0;
				end
				OP_RESTART_CONF: begin
					if (chan != CH_READY) valid_here = 1'b0;
				end
				default: valid_here = 1'b0;
				endcase
				if (!valid_here)
					r.action = ACT_DROP;
			end
			r.chan = chan;
			r.retries = retries;
			r.wclosed = win_full;
			r.rpend = rst_pend;
			r.ipend = intr_pend;
			if (retries > peak_retries)
				peak_retries = retries;
			case (r.action)
			ACT_SENT: n_sent++;
			ACT_HELD: n_held++;
			default:  n_drop++;
			endcase
			due.push_back(r);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			if (errors < 50)
				$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
			errors++;
		endtask

		task field_check(string what, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch(what, got, want);
		endtask

		task check_result(logic [1:0] act, logic [39:0] d);
			pkt_result_t w;
			if (due.size() == 0) begin
				report_mismatch("result with no request waiting", 32'(act), 32'd0);
				return;
			end
			w = due.pop_front();
			field_check("action", 32'(act), 32'(w.action));
			field_check("send_seq_out", 32'(d[2:0]), 32'(w.ps));
			field_check("recv_seq_out", 32'(d[5:3]), 32'(w.pr));
			field_check("timer_start", 32'(d[6]), 32'(w.tstart));
			field_check("timer_value", 32'(d[22:7]), 32'(w.tval));
			field_check("chan_state", 32'(d[25:23]), 32'(w.chan));
			field_check("retry_count", 32'(d[33:26]), 32'(w.retries));
			field_check("window_closed", 32'(d[34]), 32'(w.wclosed));
			field_check("reset_pending", 32'(d[35]), 32'(w.rpend));
			field_check("intr_conf_pending", 32'(d[36]), 32'(w.ipend));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // from_template, recv_seq[2:0], peer_ack_edge[2:0],
	                        // peer_busy, window_reopen, zero fill
	logic [3:0]  s_tuser;   // opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // send_seq_out[2:0], recv_seq_out[2:0], timer_start,
	                        // timer_value[15:0], chan_state[2:0], retry_count[7:0],
	                        // window_closed, reset_pending, intr_conf_pending, zero fill
	logic [1:0]  m_tuser;   // action
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	channel_book book = new();
	bit          tx_steady;
	bit          rx_steady;
	int          rx_hold_req;
	int          items_sent;
	int          settings_done;

	x25_channel_output_fsm dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		else if (r < 90) return $urandom_range(1, 3);
		else if (r < 98) return $urandom_range(4, 10);
		else return $urandom_range(12, 40);
	endfunction

	task automatic push_packet(input logic [3:0] op, input bit tmpl, input logic [2:0] rseq,
			input logic [2:0] ack, input bit busy, input bit reopen);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, reopen, busy, ack, rseq, tmpl};
		do @(posedge clk); while (!s_tready);
		book.note_request(op, tmpl, rseq, ack, busy, reopen);
		items_sent++;
	endtask

	// random side fields, busy now and then
	task automatic send_op(input logic [3:0] op);
		push_packet(op, 1'($urandom_range(0, 1)), 3'($urandom), 3'($urandom),
			$urandom_range(0, 6) == 0, 1'($urandom_range(0, 1)));
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (book.due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
		REG_WINDOW_SIZE:     book.win_size = val[2:0];
		REG_RESTART_TIMEOUT: book.restart_to = val[15:0];
		REG_CALL_TIMEOUT:    book.call_to = val[15:0];
		REG_CLEAR_TIMEOUT:   book.clear_to = val[15:0];
		default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_setting(input logic [2:0] win, input logic [15:0] t_restart,
			input logic [15:0] t_call, input logic [15:0] t_clear);
		settle();
		write_reg(REG_WINDOW_SIZE, {29'd0, win});
		write_reg(REG_RESTART_TIMEOUT, {16'd0, t_restart});
		write_reg(REG_CALL_TIMEOUT, {16'd0, t_call});
		write_reg(REG_CLEAR_TIMEOUT, {16'd0, t_clear});
		settings_done++;
	endtask

	// mostly complete call and clear sessions, some restarts, broken ones and noise
	task automatic run_mix(input int n);
		int goal;
		int pick;
		goal = items_sent + n;
		while (items_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_op(OP_CALL);
				if ($urandom_range(0, 2) == 0)
					send_op(OP_RESTART_CONF);
				if ($urandom_range(0, 3) == 0)
					send_op(4'($urandom_range(0, 15)));
				repeat ($urandom_range(1, 4)) send_op(OP_CLEAR);
				send_op(OP_CLEAR_CONF);
			end else if (pick < 70) begin
				send_op(OP_RESTART);
				send_op(OP_RESTART_CONF);
				send_op(OP_CLEAR_CONF);
			end else if (pick < 85) begin
				send_op(OP_CALL);
				send_op(4'($urandom_range(0, 15)));
				send_op(OP_CLEAR_CONF);
			end else begin
				send_op(4'($urandom_range(0, 15)));
			end
		end
	endtask

	// result side: random stalls plus a long hold-off on demand
	initial begin
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!rx_steady)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.check_result(m_tuser, m_tdata);
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		rx_hold_req = 0;
		items_sent = 0;
		settings_done = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every packet type but call while ready, then a call and clear walk
		for (int k = 0; k < 16; k++) begin
			if (k != OP_CALL)
				push_packet(4'(k), 1'b0, 3'($urandom), 3'($urandom), 1'b0, 1'($urandom));
		end
		push_packet(OP_CALL, 1'b0, 3'd7, 3'd7, 1'b1, 1'b1);
		push_packet(OP_CALL, 1'b1, 3'd0, 3'd0, 1'b1, 1'b0);
		push_packet(OP_CALL, 1'b0, 3'd7, 3'd0, 1'b0, 1'b0);
		push_packet(OP_RESTART_CONF, 1'b0, 3'd0, 3'd7, 1'b0, 1'b1);
		push_packet(OP_CLEAR, 1'b0, 3'd5, 3'd2, 1'b0, 1'b0);
		push_packet(OP_CLEAR, 1'b1, 3'd2, 3'd5, 1'b1, 1'b1);
		push_packet(OP_CLEAR_CONF, 1'b0, 3'd7, 3'd7, 1'b0, 1'b0);

		for (int p = 0; p < 6; p++) begin
			case (p)
			0: apply_setting(3'd1, 16'h0000, 16'h0000, 16'h0000);
			1: apply_setting(3'd7, 16'hffff, 16'hffff, 16'hffff);
			5: apply_setting(3'd2, 16'd180, 16'd200, 16'd180);
			default: apply_setting(3'($urandom_range(1, 7)), 16'($urandom),
				16'($urandom), 16'($urandom));
			endcase
			tx_steady = (p == 3);
			rx_steady = (p == 4);
			if (p == 1) begin
				// walk into sent clear and retransmit until the count saturates
				push_packet(OP_CLEAR, 1'b1, 3'($urandom), 3'($urandom), 1'b0, 1'b0);
				push_packet(OP_CLEAR_CONF, 1'b1, 3'($urandom), 3'($urandom), 1'b0, 1'b0);
				push_packet(OP_CALL, 1'b1, 3'($urandom), 3'($urandom), 1'b0, 1'b0);
				repeat (270) push_packet(OP_CLEAR, 1'b1, 3'($urandom), 3'($urandom),
					1'($urandom), 1'($urandom));
				push_packet(OP_CLEAR_CONF, 1'b1, 3'($urandom), 3'($urandom), 1'b0, 1'b0);
			end
			if (p == 2) begin
				// result side holds off while requests keep coming, so the input stalls
				rx_hold_req = 300;
				tx_steady = 1'b1;
				run_mix(40);
				tx_steady = 1'b0;
			end
			run_mix(210);
		end

		settle();
		repeat (8) @(posedge clk);
		if (book.due.size() != 0)
			book.report_mismatch("results never delivered", 0, book.due.size());
		$display("covered %0d requests over %0d register settings: %0d sent, %0d held, %0d dropped",
			items_sent, settings_done, book.n_sent, book.n_held, book.n_drop);
		$display("clear retries reached %0d, mismatches counted %0d",
			book.peak_retries, book.errors);
		if (book.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
